FILE: sv/uv_sphere_vertex_generator_top_macros.svh
// assertion macros for the sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define USVG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// non-overlapping implication check
`define USVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/usvg_pkg.sv
// shared types, constants and corner offset table for the sphere vertex generator
package usvg_pkg;

  localparam int IDX_W = 23;
  localparam int NORM_W = 16;
  localparam int RC_W = 11;
  localparam int RING_W = 10;
  localparam int CORNERS = 6;
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_CENTER_Z    = 3'd3,
    REG_PHI_STEP    = 3'd4,
    REG_THETA_STEP  = 3'd5,
    REG_THETA_START = 3'd6,
    REG_RING_COUNT  = 3'd7
  } reg_idx_t;

  // corner offsets: bit0 adds phi step, bit1 adds theta step
  function automatic logic [1:0] corner_offs(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0: r = 2'b00;
      3'd1: r = 2'b01;
      3'd2: r = 2'b10;
      3'd3: r = 2'b10;
      3'd4: r = 2'b01;
      3'd5: r = 2'b11;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/usvg_sine.sv
// pipelined fixed point sine, q14 result, five register stages
module usvg_sine import usvg_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic [ANGLE_BITS-1:0]   angle,
  output logic signed [15:0]      sine
);
  logic [1:0]  q0;
  logic [ANGLE_BITS-3:0] f0;
  logic [16:0] x0;
  logic [16:0] x_r1, x_r2, x_r3, x_r4;
  logic [3:0]  neg_r;
  logic [17:0] x2_r2, x2_r3;
  logic [16:0] t_r3;
  logic [17:0] t_r4;
  logic [33:0] sq;
  logic [34:0] p3;
  logic [35:0] p4;
  logic [35:0] p5;
  logic [17:0] t5;
  logic [15:0] s5;

  assign q0 = angle[ANGLE_BITS-1 -: 2];
  assign f0 = angle[ANGLE_BITS-3:0];
  // f scaled to q16: (f << 8) >> (ANGLE_BITS-10)
  always_comb begin
    logic [ANGLE_BITS+5:0] fs;
    fs = {6'd0, f0, 2'b00} << 6;
    x0 = 17'(fs >> (ANGLE_BITS - 10));
    if (q0[0]) x0 = 17'(17'h10000 - x0);
  end

  assign sq = x_r1 * x_r1;
  assign p3 = 35'(x2_r2) * 35'(4640);
  assign p4 = 36'(18'd42048 - {1'b0, t_r3}) * 36'(x2_r3);
  assign p5 = 36'(18'd102944 - t_r4) * 36'(x_r4);
  assign t5 = 18'(p5 >> 16);
  assign s5 = 16'((t5 + 18'd2) >> 2);

  always_ff @(posedge clk) begin
    x_r1  <= x0;
    neg_r <= {neg_r[2:0], q0[1]};
    x_r2  <= x_r1;
    x2_r2 <= 18'(sq >> 16);
    x_r3  <= x_r2;
    x2_r3 <= x2_r2;
    t_r3  <= 17'(p3 >> 16);
    x_r4  <= x_r3;
    t_r4  <= 18'(p4 >> 16);
    sine  <= neg_r[3] ? -$signed(s5) : $signed(s5);
  end
endmodule

FILE: sv/usvg_front.sv
// front end: cell angles and base index, queued toward the vertex pipe
module usvg_front import usvg_pkg::*; #(
  parameter int MAX_COUNT  = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [RING_W-1:0]     ring,
  input  logic [RING_W-1:0]     seg,
  input  logic [ANGLE_BITS-1:0] phi_step,
  input  logic [ANGLE_BITS-1:0] theta_step,
  input  logic [ANGLE_BITS-1:0] theta_start,
  input  logic [RC_W-1:0]       ring_count,
  input  logic                  pop,
  output logic                  q_valid,
  output logic [ANGLE_BITS-1:0] q_phi,
  output logic [ANGLE_BITS-1:0] q_theta,
  output logic [IDX_W-1:0]      q_base
);
  localparam int PW = $clog2(QDEPTH);
  logic [ANGLE_BITS-1:0] phi_m [QDEPTH];
  logic [ANGLE_BITS-1:0] th_m  [QDEPTH];
  logic [IDX_W-1:0]      base_m[QDEPTH];
  logic [PW:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wp_r, rp_r;
  logic push;
  logic [RC_W-1:0] rc;
  logic [IDX_W-1:0] cellno;

  assign rc = (32'(ring_count) > 32'(MAX_COUNT)) ? RC_W'(MAX_COUNT) : ring_count;
  assign cellno = IDX_W'(seg) * IDX_W'(rc) + IDX_W'(ring);
  assign busy = (cnt_r == (PW+1)'(QDEPTH));
  assign push = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_phi = phi_m[rp_r];
  assign q_theta = th_m[rp_r];
  assign q_base = base_m[rp_r];
  assign cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
    if (push) begin
      phi_m[wp_r]  <= ANGLE_BITS'(seg * phi_step);
      th_m[wp_r]   <= ANGLE_BITS'(theta_start + ring * theta_step);
      base_m[wp_r] <= IDX_W'({cellno, 2'b00} + {cellno, 1'b0});
    end
  end
endmodule

FILE: sv/usvg_back.sv
// back end: walks six corners, sines, normals and positions in a pipeline
module usvg_back import usvg_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [ANGLE_BITS-1:0]        q_phi,
  input  logic [ANGLE_BITS-1:0]        q_theta,
  input  logic [IDX_W-1:0]             q_base,
  output logic                         pop,
  input  logic [ANGLE_BITS-1:0]        phi_step,
  input  logic [ANGLE_BITS-1:0]        theta_step,
  input  logic [COORD_BITS-2:0]        radius,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_idx,
  output logic signed [COORD_BITS-1:0] out_px,
  output logic signed [COORD_BITS-1:0] out_py,
  output logic signed [COORD_BITS-1:0] out_pz,
  output logic signed [NORM_W-1:0]     out_nx,
  output logic signed [NORM_W-1:0]     out_ny,
  output logic signed [NORM_W-1:0]     out_nz,
  output logic                         out_last
);
  localparam int SD = 5;         // sine latency
  localparam int LAT = SD + 3;   // corner to output
  localparam int PW = COORD_BITS + 18;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [2:0] k_r;
  logic [ANGLE_BITS-1:0] ph, th;
  logic [1:0] offs;
  logic signed [15:0] sp, cp, st, ct;
  logic [LAT-1:0] v_r;
  logic [LAT-1:0] last_d;
  logic [IDX_W-1:0] idx_d [LAT];
  logic signed [31:0] pnx, pnz;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r, nx_r2, ny_r2, nz_r2, nx_r3, ny_r3, nz_r3;
  logic signed [PW-1:0] prx, pry, prz;
  logic signed [COORD_BITS:0] rx_r, ry_r, rz_r;

  function automatic logic signed [NORM_W-1:0] rq14n(input logic signed [31:0] v);
    logic [31:0] a;
    logic [31:0] m;
    a = v[31] ? 32'(-v) : 32'(v);
    m = (a + 32'd8192) >> 14;
    return v[31] ? -$signed(NORM_W'(m)) : $signed(NORM_W'(m));
  endfunction

  function automatic logic signed [COORD_BITS:0] rq14p(input logic signed [PW-1:0] v);
    logic [PW-1:0] a;
    logic [PW-1:0] m;
    a = v[PW-1] ? PW'(-v) : PW'(v);
    m = (a + PW'(8192)) >> 14;
    return v[PW-1] ? -$signed((COORD_BITS+1)'(m)) : $signed((COORD_BITS+1)'(m));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [COORD_BITS+1:0] v);
    logic signed [COORD_BITS+1:0] hi, lo;
    hi = (COORD_BITS+2)'((64'sd1 <<< (COORD_BITS-1)) - 1);
    lo = -(COORD_BITS+2)'(64'sd1 <<< (COORD_BITS-1));
    if (v > hi) return hi[COORD_BITS-1:0];
    if (v < lo) return lo[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  assign pop = q_valid && (k_r == 3'd5);
  assign offs = corner_offs(k_r);
  assign ph = q_phi + (offs[0] ? phi_step : '0);
  assign th = q_theta + (offs[1] ? theta_step : '0);

  usvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sp (.clk, .angle(ph), .sine(sp));
  usvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cp (.clk, .angle(ANGLE_BITS'(ph + QTR)), .sine(cp));
  usvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_st (.clk, .angle(th), .sine(st));
  usvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_ct (.clk, .angle(ANGLE_BITS'(th + QTR)), .sine(ct));

  assign pnx = cp * ct;
  assign pnz = -(sp * ct);
  assign prx = $signed({1'b0, radius}) * nx_r;
  assign pry = $signed({1'b0, radius}) * ny_r;
  assign prz = $signed({1'b0, radius}) * nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      v_r <= '0;
    end else begin
      if (q_valid) k_r <= (k_r == 3'd5) ? 3'd0 : k_r + 3'd1;
      v_r <= {v_r[LAT-2:0], q_valid};
    end
    idx_d[0] <= q_base + IDX_W'(k_r);
    for (int i = 1; i < LAT; i++) idx_d[i] <= idx_d[i-1];
    // stage after sines: normals
    nx_r <= rq14n(pnx);
    ny_r <= st;
    nz_r <= rq14n(pnz);
    // radius products
    rx_r <= rq14p(prx);
    ry_r <= rq14p(pry);
    rz_r <= rq14p(prz);
    nx_r2 <= nx_r; ny_r2 <= ny_r; nz_r2 <= nz_r;
    // center add and clamp
    out_px <= sat((COORD_BITS+2)'(cx) + (COORD_BITS+2)'(rx_r));
    out_py <= sat((COORD_BITS+2)'(cz) + (COORD_BITS+2)'(ry_r));
    out_pz <= sat(-(COORD_BITS+2)'(cy) + (COORD_BITS+2)'(rz_r));
    nx_r3 <= nx_r2; ny_r3 <= ny_r2; nz_r3 <= nz_r2;
  end

  assign out_valid = v_r[LAT-1];
  assign out_idx = idx_d[LAT-1];
  assign out_nx = nx_r3;
  assign out_ny = ny_r3;
  assign out_nz = nz_r3;
  assign out_last = out_valid && last_d[LAT-1];

  always_ff @(posedge clk) begin
    last_d <= {last_d[LAT-2:0], (k_r == 3'd5)};
  end
endmodule

FILE: sv/uv_sphere_vertex_generator_top.sv
// top level of the sphere vertex generator: registers, front, queue, back
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+---------------------------
//  input    | in_ring_index, in_segment_index     | start high, busy low
//  result   | out_vertex_index .. out_last_vertex | out_valid strobe, 1 cycle
//  config   | cfg_we, cfg_index, cfg_data         | write when cfg_we high
//
// each cell yields six vertices, one per cycle: the corner sequencer in the
// back end walks all six corners of a cell before it takes the next one
// with the back end idle, a cell passes the queue, sine, normal, radius and position registers
// a four deep queue holds accepted cells; busy rises only when it is full
// synchronous active low reset clears control and restores register defaults
// results cannot be stalled by the receiver
`include "uv_sphere_vertex_generator_top_macros.svh"
module uv_sphere_vertex_generator_top import usvg_pkg::*; #(
  parameter int MAX_COUNT  = 1024,
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [RING_W-1:0]            in_ring_index,
  input  logic [RING_W-1:0]            in_segment_index,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_vertex_index,
  output logic signed [COORD_BITS-1:0] out_pos_x,
  output logic signed [COORD_BITS-1:0] out_pos_y,
  output logic signed [COORD_BITS-1:0] out_pos_z,
  output logic signed [NORM_W-1:0]     out_norm_x,
  output logic signed [NORM_W-1:0]     out_norm_y,
  output logic signed [NORM_W-1:0]     out_norm_z,
  output logic                         out_last_vertex
);
  logic [COORD_BITS-2:0] radius_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;
  logic [ANGLE_BITS-1:0] phi_step_r, theta_step_r, theta_start_r;
  logic [RC_W-1:0] ring_count_r;
  logic q_valid, pop;
  logic [ANGLE_BITS-1:0] q_phi, q_theta;
  logic [IDX_W-1:0] q_base;
  logic last_raw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= (COORD_BITS-1)'(4096);
      cx_r          <= '0;
      cy_r          <= '0;
      cz_r          <= '0;
      phi_step_r    <= ANGLE_BITS'(4096);
      theta_step_r  <= ANGLE_BITS'(4096);
      theta_start_r <= ANGLE_BITS'(32768);
      ring_count_r  <= RC_W'(16);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS:      radius_r      <= cfg_data[COORD_BITS-2:0];
        REG_CENTER_X:    cx_r          <= cfg_data;
        REG_CENTER_Y:    cy_r          <= cfg_data;
        REG_CENTER_Z:    cz_r          <= cfg_data;
        REG_PHI_STEP:    phi_step_r    <= ANGLE_BITS'(cfg_data);
        REG_THETA_STEP:  theta_step_r  <= ANGLE_BITS'(cfg_data);
        REG_THETA_START: theta_start_r <= ANGLE_BITS'(cfg_data);
        REG_RING_COUNT:  ring_count_r  <= cfg_data[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: angles, cell base index, queue
  usvg_front #(.MAX_COUNT(MAX_COUNT), .ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst_n, .start, .busy,
    .ring(in_ring_index), .seg(in_segment_index),
    .phi_step(phi_step_r), .theta_step(theta_step_r),
    .theta_start(theta_start_r), .ring_count(ring_count_r),
    .pop, .q_valid, .q_phi, .q_theta, .q_base
  );

  // back end: corner walk and vertex math
  usvg_back #(.ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_phi, .q_theta, .q_base, .pop,
    .phi_step(phi_step_r), .theta_step(theta_step_r),
    .radius(radius_r), .cx(cx_r), .cy(cy_r), .cz(cz_r),
    .out_valid, .out_idx(out_vertex_index),
    .out_px(out_pos_x), .out_py(out_pos_y), .out_pz(out_pos_z),
    .out_nx(out_norm_x), .out_ny(out_norm_y), .out_nz(out_norm_z),
    .out_last(last_raw)
  );

  assign out_last_vertex = last_raw;

  // a cell leaves the queue only while the back end is walking corners
  `USVG_ASSERT(a_pop_needs_item, !pop || q_valid, "queue popped while empty")
  // last flag only on a valid result
  `USVG_ASSERT(a_last_valid, !out_last_vertex || out_valid, "last flag without result")
  // after a last vertex, the pipe keeps streaming or goes quiet, never flags twice in a row
  `USVG_ASSERT_NEXT(a_last_once, out_last_vertex, !out_last_vertex, "last flagged twice")
endmodule

FILE: tb/tb_uv_sphere_vertex_generator_top.sv
// testbench for the sphere vertex generator: directed and random cells checked per vertex
module tb_uv_sphere_vertex_generator_top;
  import usvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 24;
  localparam int MAX_COUNT = 1024;
  localparam int STALL_LIMIT = 2000;
  // drain margin: queue, path to the first vertex, six vertices
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic last_vertex;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RING_W-1:0] in_ring_index = '0;
  logic [RING_W-1:0] in_segment_index = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic out_valid;
  vertex_t got;

  // shadow copy of the configuration registers
  logic [22:0] sh_radius;
  logic signed [COORD_BITS-1:0] sh_cx, sh_cy, sh_cz;
  logic [ANGLE_BITS-1:0] sh_phi_step, sh_theta_step, sh_theta_start;
  logic [RC_W-1:0] sh_ring_count;

  vertex_t expected_vertices[$];
  int errors = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  uv_sphere_vertex_generator_top #(
    .MAX_COUNT(MAX_COUNT), .ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ring_index(in_ring_index), .in_segment_index(in_segment_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_vertex_index(got.vertex_index),
    .out_pos_x(got.pos_x), .out_pos_y(got.pos_y), .out_pos_z(got.pos_z),
    .out_norm_x(got.norm_x), .out_norm_y(got.norm_y), .out_norm_z(got.norm_z),
    .out_last_vertex(got.last_vertex)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // divide by 2^14, half away from zero
  function automatic longint q14_round(input longint v);
    if (v < 0) return -((-v + 8192) >>> 14);
    return (v + 8192) >>> 14;
  endfunction

  // polynomial sine in Q14 on a turn fraction
  function automatic longint sine_q14(input longint unsigned a);
    longint unsigned quad, frac, x, x2, t;
    longint s;
    a = a & ((64'd1 << ANGLE_BITS) - 1);
    quad = a >> (ANGLE_BITS - 2);
    frac = a & ((64'd1 << (ANGLE_BITS - 2)) - 1);
    x = (frac << 8) >> (ANGLE_BITS - 10);
    if (quad[0]) x = 65536 - x;
    x2 = (x * x) >> 16;
    t = (4640 * x2) >> 16;
    t = 42048 - t;
    t = (t * x2) >> 16;
    t = 102944 - t;
    t = (t * x) >> 16;
    s = longint'((t + 2) >> 2);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint cosine_q14(input longint unsigned a);
    return sine_q14(a + (64'd1 << (ANGLE_BITS - 2)));
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
    longint lim;
    lim = longint'(1) <<< (COORD_BITS - 1);
    if (v > lim - 1) v = lim - 1;
    if (v < -lim) v = -lim;
    return v[COORD_BITS-1:0];
  endfunction

  // six vertices of one cell, pushed in emission order
  task automatic predict_cell_vertices(input logic [RING_W-1:0] ring,
                                       input logic [RING_W-1:0] seg);
    longint unsigned rc, phi0, th0, ph, th, amask, base;
    longint cp, sp, ct, st, nx, ny, nz, r;
    logic [1:0] offs;
    vertex_t v;
    amask = (64'd1 << ANGLE_BITS) - 1;
    rc = (sh_ring_count > MAX_COUNT) ? MAX_COUNT : sh_ring_count;
    phi0 = (longint'(seg) * sh_phi_step) & amask;
    th0 = (sh_theta_start + longint'(ring) * sh_theta_step) & amask;
    base = 6 * (longint'(seg) * rc + ring);
    r = longint'(sh_radius);
    for (int k = 0; k < CORNERS; k++) begin
      offs = corner_offs(3'(k));
      ph = (phi0 + (offs[0] ? sh_phi_step : 0)) & amask;
      th = (th0 + (offs[1] ? sh_theta_step : 0)) & amask;
      cp = cosine_q14(ph);
      sp = sine_q14(ph);
      ct = cosine_q14(th);
      st = sine_q14(th);
      nx = q14_round(cp * ct);
      ny = st;
      nz = q14_round(-(sp * ct));
      v.vertex_index = IDX_W'(base + k);
      v.pos_x = clamp_coord(longint'(sh_cx) + q14_round(r * nx));
      v.pos_y = clamp_coord(longint'(sh_cz) + q14_round(r * ny));
      v.pos_z = clamp_coord(-longint'(sh_cy) + q14_round(r * nz));
      v.norm_x = nx[NORM_W-1:0];
      v.norm_y = ny[NORM_W-1:0];
      v.norm_z = nz[NORM_W-1:0];
      v.last_vertex = (k == CORNERS - 1);
      expected_vertices.push_back(v);
    end
  endtask

  // sender gap burst with start held low, about a third of the time
  task automatic sender_gap();
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // one cell transfer; start stays high until busy is low at an edge
  task automatic send_cell(input logic [RING_W-1:0] ring, input logic [RING_W-1:0] seg);
    sender_gap();
    start <= 1'b1;
    in_ring_index <= ring;
    in_segment_index <= seg;
    do @(posedge clk); while (busy);
    predict_cell_vertices(ring, seg);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write while idle, mirrored into the shadow copy
  task automatic write_reg(input reg_idx_t idx, input logic [COORD_BITS-1:0] value);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS:      sh_radius = value[22:0];
      REG_CENTER_X:    sh_cx = value;
      REG_CENTER_Y:    sh_cy = value;
      REG_CENTER_Z:    sh_cz = value;
      REG_PHI_STEP:    sh_phi_step = value[ANGLE_BITS-1:0];
      REG_THETA_STEP:  sh_theta_step = value[ANGLE_BITS-1:0];
      REG_THETA_START: sh_theta_start = value[ANGLE_BITS-1:0];
      REG_RING_COUNT:  sh_ring_count = value[RC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_random_cells(input int n);
    for (int i = 0; i < n; i++)
      send_cell(RING_W'($urandom_range(0, 1023)), RING_W'($urandom_range(0, 1023)));
  endtask

  // field extremes and corner sequencing under reset defaults
  task automatic test_directed_defaults();
    send_cell(10'd0, 10'd0);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd1023, 10'd0);
    send_cell(10'd0, 10'd1023);
    send_cell(10'h2aa, 10'h155);
    send_cell(10'h155, 10'h2aa);
    send_cell(10'd3, 10'd5);
  endtask

  // large radius and far centers drive positions into saturation
  task automatic test_position_saturation();
    write_reg(REG_RADIUS, 24'h7fffff);
    write_reg(REG_CENTER_X, 24'h7fffff);
    write_reg(REG_CENTER_Y, 24'h800000);
    write_reg(REG_CENTER_Z, 24'h800000);
    for (int i = 0; i < 4; i++) send_cell(RING_W'(i), RING_W'(3 * i));
    wait_drained();
    write_reg(REG_CENTER_X, 24'h800000);
    write_reg(REG_CENTER_Y, 24'h7fffff);
    write_reg(REG_CENTER_Z, 24'h7fffff);
    for (int i = 0; i < 4; i++) send_cell(RING_W'(8 * i), RING_W'(i));
    wait_drained();
  endtask

  // angle wrap, zero steps, ring count zero and above the maximum
  task automatic test_angle_and_index_wrap();
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_CENTER_X, 24'd0);
    write_reg(REG_CENTER_Y, 24'd0);
    write_reg(REG_CENTER_Z, 24'd0);
    write_reg(REG_PHI_STEP, 24'hffff);
    write_reg(REG_THETA_STEP, 24'hffff);
    write_reg(REG_THETA_START, 24'hffff);
    write_reg(REG_RING_COUNT, 24'h7ff);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd1, 10'd1);
    wait_drained();
    write_reg(REG_PHI_STEP, 24'd0);
    write_reg(REG_THETA_STEP, 24'd0);
    write_reg(REG_THETA_START, 24'd0);
    write_reg(REG_RING_COUNT, 24'd0);
    send_cell(10'd7, 10'd9);
    wait_drained();
    write_reg(REG_RING_COUNT, 24'd1025);
    send_cell(10'd1023, 10'd1023);
    wait_drained();
  endtask

  // random cells under several register settings
  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_RADIUS,
                COORD_BITS'($urandom_range(0, 24'h7fffff) >> $urandom_range(0, 12)));
      write_reg(REG_CENTER_X, COORD_BITS'($urandom() >> $urandom_range(8, 20)));
      write_reg(REG_CENTER_Y, COORD_BITS'($urandom()));
      write_reg(REG_CENTER_Z, COORD_BITS'(-($urandom() >> 14)));
      write_reg(REG_PHI_STEP, COORD_BITS'($urandom_range(0, 65535)));
      write_reg(REG_THETA_STEP, COORD_BITS'($urandom_range(0, 65535)));
      write_reg(REG_THETA_START, COORD_BITS'($urandom_range(0, 65535)));
      write_reg(REG_RING_COUNT, COORD_BITS'($urandom_range(0, 2047)));
      send_random_cells(40);
      // in the third setting only, the sender holds off until every vertex has come back
      if (p == 2) wait_drained();
      send_random_cells(10);
      wait_drained();
    end
  endtask

  // back to back with no gaps at the end of the run
  task automatic test_back_to_back();
    allow_gaps = 1'b0;
    write_reg(REG_RADIUS, 24'd4096);
    write_reg(REG_RING_COUNT, 24'd16);
    send_random_cells(12);
  endtask

  // result checker: every strobed vertex against the oldest prediction
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_valid) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex with none expected: index %0d", got.vertex_index);
        errors++;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got.vertex_index !== exp_v.vertex_index) begin
          $error("vertex_index exp %0d got %0d", exp_v.vertex_index, got.vertex_index);
          errors++;
        end
        if (got.pos_x !== exp_v.pos_x) begin
          $error("pos_x exp %0d got %0d", exp_v.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== exp_v.pos_y) begin
          $error("pos_y exp %0d got %0d", exp_v.pos_y, got.pos_y);
          errors++;
        end
        if (got.pos_z !== exp_v.pos_z) begin
          $error("pos_z exp %0d got %0d", exp_v.pos_z, got.pos_z);
          errors++;
        end
        if (got.norm_x !== exp_v.norm_x) begin
          $error("norm_x exp %0d got %0d", exp_v.norm_x, got.norm_x);
          errors++;
        end
        if (got.norm_y !== exp_v.norm_y) begin
          $error("norm_y exp %0d got %0d", exp_v.norm_y, got.norm_y);
          errors++;
        end
        if (got.norm_z !== exp_v.norm_z) begin
          $error("norm_z exp %0d got %0d", exp_v.norm_z, got.norm_z);
          errors++;
        end
        if (got.last_vertex !== exp_v.last_vertex) begin
          $error("last_vertex exp %0d got %0d", exp_v.last_vertex, got.last_vertex);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither a cell transfer nor a vertex
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sh_radius = 23'd4096;
    sh_cx = '0;
    sh_cy = '0;
    sh_cz = '0;
    sh_phi_step = 16'd4096;
    sh_theta_step = 16'd4096;
    sh_theta_start = 16'd32768;
    sh_ring_count = 11'd16;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    wait_drained();
    test_position_saturation();
    test_angle_and_index_wrap();
    test_random_settings();
    test_back_to_back();
    wait_drained();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
